// File: hdl/fat12_pkg.sv
// Package for the FAT12 table engine: command codes, status codes and table constants.
`default_nettype none

package fat12_pkg;

	typedef enum logic [2:0] {
		CMD_READ_ENTRY  = 3'd0,
		CMD_WRITE_ENTRY = 3'd1,
		CMD_FIND_FREE   = 3'd2,
		CMD_COUNT_FREE  = 3'd3,
		CMD_FREE_CHAIN  = 3'd4,
		CMD_FOLLOW      = 3'd5,
		CMD_WRITE_BYTE  = 3'd6,
		CMD_READ_BYTE   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NONE    = 2'd1,
		ST_LIMIT   = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	localparam int unsigned TABLE_BYTES  = 6144;
	localparam int unsigned ENTRY_COUNT  = 4096;
	localparam logic [11:0] CHAIN_END    = 12'hFF0;
	localparam logic [12:0] TOTAL_RESET  = 13'd2880;

endpackage

`default_nettype wire

// File: hdl/fat12_table_engine_top.sv
// Top level of the FAT12 table engine: packed byte table, sequencer and result register.
//
// Channel   | Direction | Handshake                       | Payload
// ----------+-----------+---------------------------------+-------------------------------
// command   | in        | start high while busy low       | cmd, position, value, steps
// result    | out       | result_valid, one cycle         | result_value, found, status
// config    | in        | cfg_write high                  | cfg_data (total_entries)
//
// The table sits in one 6144 x 8 memory with one write port and one registered read port.
// A raw byte write answers in the cycle after its transfer, a raw byte read after S_BYTE_RD.
// Each entry access reads two bytes through the single read port in S_RD_A, S_RD_B and
// S_EVAL, so an entry read answers from S_EVAL; an entry write adds S_WR_B for its second
// byte write and answers from there. Scans pass these states once per entry visited, chain
// follow once per link, and chain free adds S_WR_B per link. The memory has no reset and
// needs no clearing pass; reset clears the sequencer and sets total_entries to 2880. The
// receiver cannot stall: each result is shown for one cycle with result_valid high.
`default_nettype none

module fat12_table_engine_top #(
	parameter int MAX_ENTRIES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  cmd,
	input  wire logic [12:0] position,
	input  wire logic [11:0] value,
	input  wire logic [11:0] steps,
	output logic             result_valid,
	output logic [12:0]      result_value,
	output logic             found,
	output logic [1:0]       status,
	input  wire logic        cfg_write,
	input  wire logic [12:0] cfg_data
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_RD_A    = 6'b000010,
		S_RD_B    = 6'b000100,
		S_EVAL    = 6'b001000,
		S_WR_B    = 6'b010000,
		S_BYTE_RD = 6'b100000
	} state_t;

	localparam logic [12:0] MAX_WALK = 13'(MAX_ENTRIES);

	state_t state_q;

	// Table storage and its ports
	logic [7:0]  mem [fat12_pkg::TABLE_BYTES];
	logic [12:0] raddr;
	logic [7:0]  rdata_q;
	logic        we;
	logic [12:0] waddr;
	logic [7:0]  wdata;

	// Latched command and walk state
	fat12_pkg::cmd_t cmd_q;
	logic [12:0] pos_q;
	logic [11:0] val_q;
	logic [11:0] steps_q;
	logic [11:0] idx_q;
	logic [12:0] cnt_q;
	logic [12:0] addr_q;
	logic [7:0]  a_byte_q;
	logic [7:0]  b_byte_q;
	logic [11:0] ent_q;
	logic [12:0] total_q;

	logic [12:0] scan_lim;
	logic [12:0] addr_a;
	logic [11:0] entry;
	logic [11:0] wr_val;
	logic [12:0] cnt_inc;
	logic [12:0] idx_inc;
	logic        entry_zero;
	fat12_pkg::cmd_t cmd_in;

	assign cmd_in   = fat12_pkg::cmd_t'(cmd);
	assign busy     = (state_q != S_IDLE);
	assign scan_lim = (total_q > 13'(fat12_pkg::ENTRY_COUNT)) ?
		13'(fat12_pkg::ENTRY_COUNT) : total_q;

	// First byte of an entry: 3*(n/2), plus one for an odd entry
	assign addr_a = {1'b0, idx_q[11:1], 1'b0} + {2'b00, idx_q[11:1]} + {12'd0, idx_q[0]};

	// Even entry: low byte then low nibble of the middle; odd: high nibble then next byte
	assign entry = idx_q[0] ? {rdata_q, a_byte_q[7:4]} : {rdata_q[3:0], a_byte_q};

	assign wr_val     = (cmd_q == fat12_pkg::CMD_WRITE_ENTRY) ? val_q : 12'd0;
	assign cnt_inc    = cnt_q + 13'd1;
	assign idx_inc    = {1'b0, idx_q} + 13'd1;
	assign entry_zero = (entry == 12'd0);

	// Read address and write port
	always_comb begin
		raddr = position;
		we    = 1'b0;
		waddr = addr_q;
		wdata = 8'd0;
		unique case (state_q)
			S_IDLE: begin
				raddr = position;
				if (start && cmd_in == fat12_pkg::CMD_WRITE_BYTE &&
						position < 13'(fat12_pkg::TABLE_BYTES)) begin
					we    = 1'b1;
					waddr = position;
					wdata = value[7:0];
				end
			end
			S_RD_A: raddr = addr_a;
			S_RD_B: raddr = addr_q + 13'd1;
			S_EVAL: begin
				raddr = addr_q;
				if (cmd_q == fat12_pkg::CMD_WRITE_ENTRY || cmd_q == fat12_pkg::CMD_FREE_CHAIN) begin
					we    = 1'b1;
					waddr = addr_q;
					wdata = idx_q[0] ? {wr_val[3:0], a_byte_q[3:0]} : wr_val[7:0];
				end
			end
			S_WR_B: begin
				raddr = addr_q;
				we    = 1'b1;
				waddr = addr_q + 13'd1;
				wdata = idx_q[0] ? wr_val[11:4] : {b_byte_q[7:4], wr_val[11:8]};
			end
			S_BYTE_RD: raddr = pos_q;
			default: raddr = position;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= fat12_pkg::TOTAL_RESET;
		end else if (cfg_write) begin
			total_q <= cfg_data;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			result_value <= 13'd0;
			found        <= 1'b0;
			status       <= 2'(fat12_pkg::ST_OK);
			cmd_q        <= fat12_pkg::CMD_READ_ENTRY;
			pos_q        <= 13'd0;
			val_q        <= 12'd0;
			steps_q      <= 12'd0;
			idx_q        <= 12'd0;
			cnt_q        <= 13'd0;
			addr_q       <= 13'd0;
			a_byte_q     <= 8'd0;
			b_byte_q     <= 8'd0;
			ent_q        <= 12'd0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd_in;
						pos_q   <= position;
						val_q   <= value;
						steps_q <= steps;
						cnt_q   <= 13'd0;
						found   <= 1'b0;
						status  <= 2'(fat12_pkg::ST_OK);
						unique case (cmd_in)
							fat12_pkg::CMD_READ_ENTRY, fat12_pkg::CMD_WRITE_ENTRY: begin
								idx_q   <= position[11:0];
								state_q <= S_RD_A;
							end
							fat12_pkg::CMD_FIND_FREE, fat12_pkg::CMD_COUNT_FREE: begin
								idx_q <= 12'd0;
								if (scan_lim == 13'd0) begin
									// Empty scan range: answer at once
									result_valid <= 1'b1;
									result_value <= 13'd0;
									status       <= (cmd_in == fat12_pkg::CMD_FIND_FREE) ?
										2'(fat12_pkg::ST_NONE) : 2'(fat12_pkg::ST_OK);
								end else begin
									state_q <= S_RD_A;
								end
							end
							fat12_pkg::CMD_FREE_CHAIN: begin
								idx_q <= position[11:0];
								if (position[11:0] >= fat12_pkg::CHAIN_END) begin
									result_valid <= 1'b1;
									result_value <= 13'd0;
								end else begin
									state_q <= S_RD_A;
								end
							end
							fat12_pkg::CMD_FOLLOW: begin
								idx_q <= position[11:0];
								if (steps == 12'd0) begin
									result_valid <= 1'b1;
									result_value <= {1'b0, position[11:0]};
									found        <= 1'b1;
								end else begin
									state_q <= S_RD_A;
								end
							end
							fat12_pkg::CMD_WRITE_BYTE: begin
								result_valid <= 1'b1;
								result_value <= {5'd0, value[7:0]};
							end
							fat12_pkg::CMD_READ_BYTE: begin
								state_q <= S_BYTE_RD;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RD_A: begin
					addr_q  <= addr_a;
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					a_byte_q <= rdata_q;
					state_q  <= S_EVAL;
				end
				S_EVAL: begin
					b_byte_q <= rdata_q;
					ent_q    <= entry;
					state_q  <= S_IDLE;
					unique case (cmd_q)
						fat12_pkg::CMD_READ_ENTRY: begin
							result_valid <= 1'b1;
							result_value <= {1'b0, entry};
						end
						fat12_pkg::CMD_WRITE_ENTRY, fat12_pkg::CMD_FREE_CHAIN: begin
							state_q <= S_WR_B;
						end
						fat12_pkg::CMD_FIND_FREE: begin
							if (entry_zero) begin
								result_valid <= 1'b1;
								result_value <= {1'b0, idx_q};
								found        <= 1'b1;
							end else if (idx_inc == scan_lim) begin
								result_valid <= 1'b1;
								result_value <= 13'd0;
								status       <= 2'(fat12_pkg::ST_NONE);
							end else begin
								idx_q   <= idx_inc[11:0];
								state_q <= S_RD_A;
							end
						end
						fat12_pkg::CMD_COUNT_FREE: begin
							if (idx_inc == scan_lim) begin
								result_valid <= 1'b1;
								result_value <= entry_zero ? cnt_inc : cnt_q;
							end else begin
								cnt_q   <= entry_zero ? cnt_inc : cnt_q;
								idx_q   <= idx_inc[11:0];
								state_q <= S_RD_A;
							end
						end
						fat12_pkg::CMD_FOLLOW: begin
							cnt_q <= cnt_inc;
							idx_q <= entry;
							if (entry >= fat12_pkg::CHAIN_END) begin
								// Chain ended before the requested link count
								result_valid <= 1'b1;
								result_value <= {1'b0, entry};
								status       <= 2'(fat12_pkg::ST_NONE);
							end else if (cnt_inc == {1'b0, steps_q}) begin
								result_valid <= 1'b1;
								result_value <= {1'b0, entry};
								found        <= 1'b1;
							end else if (cnt_inc >= MAX_WALK) begin
								result_valid <= 1'b1;
								result_value <= {1'b0, entry};
								status       <= 2'(fat12_pkg::ST_LIMIT);
							end else begin
								state_q <= S_RD_A;
							end
						end
						default: begin
							result_valid <= 1'b1;
							result_value <= 13'd0;
						end
					endcase
				end
				S_WR_B: begin
					state_q <= S_IDLE;
					if (cmd_q == fat12_pkg::CMD_WRITE_ENTRY) begin
						result_valid <= 1'b1;
						result_value <= {1'b0, val_q};
					end else begin
						// Advance the free walk to the next link
						cnt_q <= cnt_inc;
						idx_q <= ent_q;
						if (ent_q >= fat12_pkg::CHAIN_END) begin
							result_valid <= 1'b1;
							result_value <= cnt_inc;
						end else if (cnt_inc >= MAX_WALK) begin
							result_valid <= 1'b1;
							result_value <= cnt_inc;
							status       <= 2'(fat12_pkg::ST_LIMIT);
						end else begin
							state_q <= S_RD_A;
						end
					end
				end
				S_BYTE_RD: begin
					state_q      <= S_IDLE;
					result_valid <= 1'b1;
					result_value <= (pos_q < 13'(fat12_pkg::TABLE_BYTES)) ?
						{5'd0, rdata_q} : 13'd0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
